// ===== rtl/pileup_hit_pattern_bank_builder_assert.svh =====
// Assertion macros for the pile-up hit pattern bank builder checker.
// Depends on nothing; the including module must have ports clock and reset.
`ifndef PILEUP_HIT_PATTERN_BANK_BUILDER_ASSERT_SVH
`define PILEUP_HIT_PATTERN_BANK_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PHBB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PHBB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/phbb_pkg.sv =====
// Shared types, constants and helper functions of the hit pattern bank builder.
// Depends on nothing; every module file imports it.
package phbb_pkg;

   localparam int CHARGE_W   = 20;
   localparam int THRESH_W   = 19;
   localparam int SENSOR_W   = 8;
   localparam int STRIP_W    = 11;
   localparam int WORD_W     = 32;
   localparam int CSR_DATA_W = 19;
   localparam int STORE_AW   = 6;
   localparam int BIT_W      = 5;
   localparam int PAIR_W     = 6;
   localparam int BANK_WORDS = 68;

   // Input operation codes.
   localparam logic OP_HIT       = 1'b0;
   localparam logic OP_END_EVENT = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_CHARGE_THRESHOLD = 1'b0;
   localparam logic CSR_FIRST_SENSOR     = 1'b1;

   localparam logic [THRESH_W-1:0] THRESH_RESET       = 19'd7000;
   localparam logic [SENSOR_W-1:0] FIRST_SENSOR_RESET = 8'd0;

   localparam logic [PAIR_W-1:0] LAST_PAIR      = 6'd33;
   localparam logic [7:0]        NO_SOURCE      = 8'hFF;
   localparam logic [15:0]       REVERSED_CHIPS = 16'hE8E8;

   // Bank word to store index (sensor * 16 + chip); NO_SOURCE words read as zero.
   localparam logic [7:0] BANK_MAP [0:BANK_WORDS-1] = '{
      8'hFF, 8'hFF,
      8'd2,  8'd0,  8'd29, 8'd31, 8'd45, 8'd47, 8'd50, 8'd48,
      8'd5,  8'd7,  8'd26, 8'd24, 8'd42, 8'd40, 8'd53, 8'd55,
      8'd10, 8'd8,  8'd21, 8'd23, 8'd37, 8'd39, 8'd58, 8'd56,
      8'd13, 8'd15, 8'd18, 8'd16, 8'd34, 8'd32, 8'd61, 8'd63,
      8'hFF, 8'hFF,
      8'd1,  8'd3,  8'd30, 8'd28, 8'd46, 8'd44, 8'd49, 8'd51,
      8'd6,  8'd4,  8'd25, 8'd27, 8'd41, 8'd43, 8'd54, 8'd52,
      8'd9,  8'd11, 8'd22, 8'd20, 8'd38, 8'd36, 8'd57, 8'd59,
      8'd14, 8'd12, 8'd17, 8'd19, 8'd33, 8'd35, 8'd62, 8'd60
   };

   typedef struct packed {
      logic                       op;
      logic signed [CHARGE_W-1:0] charge;
      logic [SENSOR_W-1:0]        sensor;
      logic [STRIP_W-1:0]         strip;
      logic                       is_pileup;
   } req_type;

   typedef struct packed {
      logic [PAIR_W-1:0] pair_index;
      logic [WORD_W-1:0] word_even;
      logic [WORD_W-1:0] word_odd;
      logic              last;
   } rsp_type;

   // One queued command: a hit that passed all checks, or an end of event.
   typedef struct packed {
      logic                end_event;
      logic [STORE_AW-1:0] index;
      logic [BIT_W-1:0]    bit_pos;
   } cmd_type;

   // Handshake between the command queue and the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   function automatic logic [WORD_W-1:0] reverse_word(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      for (int i = 0; i < WORD_W; i++) begin
         r[i] = v[WORD_W-1-i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/phbb_front.sv =====
// Front end: configuration registers and hit classification.
// Depends on phbb_pkg; feeds the command queue.
module phbb_front import phbb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_push,
   input  logic                  req_full,
   input  req_type               req_data,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic [THRESH_W-1:0] thresh_ff;
   logic [SENSOR_W-1:0] first_sensor_ff;
   logic [SENSOR_W:0]   rel_sensor;
   logic                above;
   logic                in_range;
   logic                keep;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff       <= THRESH_RESET;
         first_sensor_ff <= FIRST_SENSOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHARGE_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
            CSR_FIRST_SENSOR:     first_sensor_ff <= csr_wdata[SENSOR_W-1:0];
            default:              thresh_ff <= thresh_ff;
         endcase
      end
   end

   // A negative charge never passes; otherwise compare the magnitude bits.
   assign above = !req_data.charge[CHARGE_W-1] &&
                  (req_data.charge[THRESH_W-1:0] > thresh_ff);

   // The relative sensor must lie in 0..3 without wrapping below zero.
   assign rel_sensor = {1'b0, req_data.sensor} - {1'b0, first_sensor_ff};
   assign in_range   = !rel_sensor[SENSOR_W] && (rel_sensor[SENSOR_W-1:2] == '0);

   assign keep = (req_data.op == OP_END_EVENT) ||
                 (above && req_data.is_pileup && in_range);

   // Ignored hits are dropped here and never reach the queue.
   assign q_push            = req_push && !req_full && keep;
   assign q_cmd.end_event   = (req_data.op == OP_END_EVENT);
   assign q_cmd.index       = {rel_sensor[1:0], req_data.strip[10:7]};
   assign q_cmd.bit_pos     = req_data.strip[6:2];

endmodule

// ===== rtl/phbb_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on phbb_pkg for the command type.
module phbb_queue import phbb_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   output logic         full,
   input  logic         pop,
   output cmd_head_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slots_ff [0:DEPTH-1];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slots_ff[rd_ptr_ff];

   // Storage slots.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/phbb_back.sv =====
// Back end: hit word store, read-modify-write of hits and bank readout.
// Depends on phbb_pkg; drains the command queue and drives the result register.
module phbb_back import phbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_head_type head,
   output logic         cmd_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HIT_WR,
      ST_EV_RD,
      ST_EV_PUSH
   } state_type;

   state_type           state_ff, state_in;
   logic [PAIR_W-1:0]   pair_ff, pair_in;
   logic [STORE_AW-1:0] hit_index_ff, hit_index_in;
   logic [BIT_W-1:0]    hit_bit_ff, hit_bit_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff, out_data_in;

   logic [WORD_W-1:0]   store [0:(1 << STORE_AW)-1];
   logic [(1 << STORE_AW)-1:0] valid_ff;
   logic [WORD_W-1:0]   rd_a_ff, rd_b_ff;
   logic                vld_a_ff, vld_b_ff;
   logic                nosrc_a_ff, nosrc_b_ff;
   logic                rev_a_ff, rev_b_ff;

   logic [7:0]          map_a, map_b;
   logic [STORE_AW-1:0] addr_a, addr_b;
   logic                rd_en;
   logic                wr_en;
   logic                clear_all;
   logic                slot_free;
   logic [WORD_W-1:0]   word_a, word_b, base_a, base_b;
   logic [WORD_W-1:0]   wr_data;

   // Bank word addresses of the current pair.
   assign map_a  = BANK_MAP[{pair_ff, 1'b0}];
   assign map_b  = BANK_MAP[{pair_ff, 1'b1}];
   assign addr_a = (state_ff == ST_IDLE) ? head.cmd.index : map_a[STORE_AW-1:0];
   assign addr_b = map_b[STORE_AW-1:0];

   assign rd_en = ((state_ff == ST_IDLE) && head.valid && !head.cmd.end_event) ||
                  (state_ff == ST_EV_RD);

   // Word store with one write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[hit_index_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff    <= store[addr_a];
         rd_b_ff    <= store[addr_b];
         vld_a_ff   <= valid_ff[addr_a];
         vld_b_ff   <= valid_ff[addr_b];
         nosrc_a_ff <= (map_a == NO_SOURCE);
         nosrc_b_ff <= (map_b == NO_SOURCE);
         rev_a_ff   <= REVERSED_CHIPS[map_a[3:0]];
         rev_b_ff   <= REVERSED_CHIPS[map_b[3:0]];
      end
   end

   // Per-word valid bits: an entry not written since the last event reads as zero.
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[hit_index_ff] <= 1'b1;
      end
   end

   // Hit update: OR the strip group bit into the addressed word.
   assign wr_data = (vld_a_ff ? rd_a_ff : '0) | (WORD_W'(1) << hit_bit_ff);

   // Bank words with zero slots and bit reversal applied.
   assign base_a = vld_a_ff ? rd_a_ff : '0;
   assign base_b = vld_b_ff ? rd_b_ff : '0;
   assign word_a = nosrc_a_ff ? '0 : (rev_a_ff ? reverse_word(base_a) : base_a);
   assign word_b = nosrc_b_ff ? '0 : (rev_b_ff ? reverse_word(base_b) : base_b);

   assign slot_free = !out_valid_ff || rsp_pop;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      pair_in      = pair_ff;
      hit_index_in = hit_index_ff;
      hit_bit_in   = hit_bit_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      clear_all    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               cmd_pop = 1'b1;
               if (head.cmd.end_event) begin
                  pair_in  = '0;
                  state_in = ST_EV_RD;
               end else begin
                  hit_index_in = head.cmd.index;
                  hit_bit_in   = head.cmd.bit_pos;
                  state_in     = ST_HIT_WR;
               end
            end
         end
         ST_HIT_WR: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EV_RD: begin
            state_in = ST_EV_PUSH;
         end
         ST_EV_PUSH: begin
            if (slot_free) begin
               out_valid_in           = 1'b1;
               out_data_in.pair_index = pair_ff;
               out_data_in.word_even  = word_a;
               out_data_in.word_odd   = word_b;
               out_data_in.last       = (pair_ff == LAST_PAIR);
               if (pair_ff == LAST_PAIR) begin
                  clear_all = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  pair_in  = pair_ff + 1'b1;
                  state_in = ST_EV_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      pair_ff      <= pair_in;
      hit_index_ff <= hit_index_in;
      hit_bit_ff   <= hit_bit_in;
      out_data_ff  <= out_data_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/pileup_hit_pattern_bank_builder.sv =====
// Top level of the pile-up hit pattern bank builder.
// Depends on phbb_pkg, phbb_front, phbb_queue and phbb_back.
//
//   Channel   Ports                                Transfer when
//   request   req_push, req_full, req_data         req_push && !req_full
//   response  rsp_empty, rsp_pop, rsp_data         rsp_pop && !rsp_empty
//   control   csr_we, csr_index, csr_wdata         csr_we
//
// The front end takes one item per cycle while the command queue has room.
// The back end handles each kept hit as a store read, then a write.
// An end of event is dispatched, then each pair takes a two-port store read,
// then a result register load, which waits while the result register is full.
// Reset clears the store at once through per-word valid bits; no clearing pass.
// A full result register stalls the readout; a full queue raises req_full.
module pileup_hit_pattern_bank_builder import phbb_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic         q_push;
   cmd_type      q_cmd;
   cmd_head_type head;
   logic         cmd_pop;

   // Classification and configuration.
   phbb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // Decoupling queue.
   phbb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .head     (head)
   );

   // Store and bank readout.
   phbb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/phbb_checker.sv =====
// Port-level checks of the bank builder's result stream, bound to the top level.
// Depends on phbb_pkg and pileup_hit_pattern_bank_builder_assert.svh.
`include "pileup_hit_pattern_bank_builder_assert.svh"

module phbb_checker import phbb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // A shown pair never lies beyond the end of the bank.
   `PHBB_ASSERT_NOW(a_pair_range, !rsp_empty, rsp_data.pair_index <= LAST_PAIR, "pair index out of range")

   // The last flag marks exactly the final pair.
   `PHBB_ASSERT_NOW(a_last_flag, !rsp_empty, rsp_data.last == (rsp_data.pair_index == LAST_PAIR), "last flag does not match pair index")

   // After a non-final pair is taken, the next shown pair is its successor.
   `PHBB_ASSERT_NEXT(a_pair_order, rsp_pop && !rsp_empty && !rsp_data.last, rsp_empty || (rsp_data.pair_index == $past(rsp_data.pair_index) + 1'b1), "pairs out of order")

   // A waiting result holds until it is taken.
   `PHBB_ASSERT_NEXT(a_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "result changed while stalled")

endmodule

bind pileup_hit_pattern_bank_builder phbb_checker u_checker (.*);
